// File: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master package
// Word types, action codes, phase encoding and register indexes shared by
// the bit-banged I2C master modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [3:0] WRITE_ACK_TRIES_RESET = 4'd10;
    localparam logic [3:0] READ_ACK_TRIES_RESET  = 4'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ACK_TRIES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_ACK_TRIES  = 1'd1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_START_WR = 2'd1,
        ACT_START_RD = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ADDR_NAK = 2'd1,
        STATUS_DATA_NAK = 2'd2,
        STATUS_SPARE    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START1    = 5'd1,
        PH_START2    = 5'd2,
        PH_ABIT_LOW  = 5'd3,
        PH_ABIT_HIGH = 5'd4,
        PH_AACK_LOW  = 5'd5,
        PH_AACK_HIGH = 5'd6,
        PH_DBIT_LOW  = 5'd7,
        PH_DBIT_HIGH = 5'd8,
        PH_DACK_LOW  = 5'd9,
        PH_DACK_HIGH = 5'd10,
        PH_RBIT_LOW  = 5'd11,
        PH_RBIT_HIGH = 5'd12,
        PH_MACK_LOW  = 5'd13,
        PH_MACK_HIGH = 5'd14,
        PH_STOP1     = 5'd15,
        PH_STOP2     = 5'd16,
        PH_STOP3     = 5'd17
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] dev_address;
        logic [7:0] byte_count;
        logic [7:0] tx_byte;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } i2cm_out_t;

endpackage

// File: src/i2cm_in_stage.sv
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one accepted tick word until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cm_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cm_pkg::i2cm_in_t in_data,
    input  logic              advance,
    output logic              item_valid,
    output i2cm_pkg::i2cm_in_t item
);
    import i2cm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    i2cm_in_t data_reg;

    // The held word leaves when the result stage can take its result.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// File: src/i2cm_fsm.sv
// ----------------------------------------------------------------------------
// I2C master sequencer
// Phase state machine that advances one half-bit phase per tick word and
// forms the pin levels and report fields of that tick.
// ----------------------------------------------------------------------------
module i2cm_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  i2cm_pkg::i2cm_in_t item,
    input  logic [3:0]         write_ack_tries,
    input  logic [3:0]         read_ack_tries,
    output i2cm_pkg::i2cm_out_t result
);
    import i2cm_pkg::*;

    phase_t     phase_reg,      phase_next;
    logic       is_read_reg,    is_read_next;
    logic [7:0] shift_reg,      shift_next;
    logic [3:0] bit_index_reg,  bit_index_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [3:0] try_count_reg,  try_count_next;
    logic [1:0] error_code_reg, error_code_next;

    logic [3:0] try_inc;
    logic [3:0] ack_limit;
    logic       ack_fail;
    logic       ack_ok;
    logic [3:0] bit_inc;
    logic [7:0] rx_shift;
    logic       starting;

    // Shared terms of the acknowledge check and the bit counters.
    always_comb
    begin
        try_inc   = try_count_reg + 4'd1;
        ack_limit = (phase_reg == PH_AACK_HIGH && is_read_reg) ? read_ack_tries
                                                               : write_ack_tries;
        ack_fail  = (try_inc == ack_limit);
        ack_ok    = !ack_fail && !item.sda_in;
        bit_inc   = bit_index_reg + 4'd1;
        rx_shift  = {shift_reg[6:0], item.sda_in};
        starting  = (item.action == ACT_START_WR) || (item.action == ACT_START_RD);
    end

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        shift_next      = shift_reg;
        bit_index_next  = bit_index_reg;
        bytes_left_next = bytes_left_reg;
        try_count_next  = try_count_reg;
        error_code_next = error_code_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (starting)
                begin
                    is_read_next    = (item.action == ACT_START_RD);
                    shift_next      = {item.dev_address, item.action == ACT_START_RD};
                    bytes_left_next = item.byte_count;
                    bit_index_next  = 4'd0;
                    try_count_next  = 4'd0;
                    error_code_next = STATUS_OK;
                    phase_next      = PH_START1;
                end
            end
            PH_START1:    phase_next = PH_START2;
            PH_START2:    phase_next = PH_ABIT_LOW;
            PH_ABIT_LOW:  phase_next = PH_ABIT_HIGH;
            PH_DBIT_LOW:  phase_next = PH_DBIT_HIGH;
            PH_ABIT_HIGH, PH_DBIT_HIGH:
            begin
                shift_next     = {shift_reg[6:0], 1'b0};
                bit_index_next = bit_inc;
                if (bit_inc >= BITS_PER_BYTE)
                begin
                    try_count_next = 4'd0;
                    phase_next     = (phase_reg == PH_ABIT_HIGH) ? PH_AACK_LOW : PH_DACK_LOW;
                end
                else
                begin
                    phase_next = (phase_reg == PH_ABIT_HIGH) ? PH_ABIT_LOW : PH_DBIT_LOW;
                end
            end
            PH_AACK_LOW:  phase_next = PH_AACK_HIGH;
            PH_DACK_LOW:  phase_next = PH_DACK_HIGH;
            PH_RBIT_LOW:  phase_next = PH_RBIT_HIGH;
            PH_AACK_HIGH, PH_DACK_HIGH:
            begin
                try_count_next = try_inc;
                if (ack_fail)
                begin
                    error_code_next = (phase_reg == PH_AACK_HIGH) ? STATUS_ADDR_NAK
                                                                  : STATUS_DATA_NAK;
                    phase_next = PH_STOP1;
                end
                else if (!ack_ok)
                begin
                    phase_next = (phase_reg == PH_AACK_HIGH) ? PH_AACK_LOW : PH_DACK_LOW;
                end
                else if (bytes_left_reg == 8'd0)
                begin
                    phase_next = PH_STOP1;
                end
                else if (phase_reg == PH_AACK_HIGH && is_read_reg)
                begin
                    bit_index_next = 4'd0;
                    shift_next     = 8'd0;
                    phase_next     = PH_RBIT_LOW;
                end
                else
                begin
                    // The next write byte is loaded here and reported as taken.
                    shift_next      = item.tx_byte;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    bit_index_next  = 4'd0;
                    phase_next      = PH_DBIT_LOW;
                end
            end
            PH_RBIT_HIGH:
            begin
                shift_next     = rx_shift;
                bit_index_next = bit_inc;
                if (bit_inc >= BITS_PER_BYTE)
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    phase_next      = PH_MACK_LOW;
                end
                else
                begin
                    phase_next = PH_RBIT_LOW;
                end
            end
            PH_MACK_LOW:  phase_next = PH_MACK_HIGH;
            PH_MACK_HIGH:
            begin
                if (bytes_left_reg == 8'd0)
                begin
                    phase_next = PH_STOP1;
                end
                else
                begin
                    bit_index_next = 4'd0;
                    shift_next     = 8'd0;
                    phase_next     = PH_RBIT_LOW;
                end
            end
            PH_STOP1:     phase_next = PH_STOP2;
            PH_STOP2:     phase_next = PH_STOP3;
            PH_STOP3:     phase_next = PH_IDLE;
            default:      phase_next = PH_IDLE;
        endcase
    end

    // Outputs of the tick: pin levels belong to the phase on entry.
    always_comb
    begin
        result          = '0;
        result.busy_res = (phase_next != PH_IDLE);
        case (phase_reg)
            PH_START1:
            begin
                result.sda_low = 1'b1;
            end
            PH_START2, PH_STOP1:
            begin
                result.scl_low = 1'b1;
                result.sda_low = 1'b1;
            end
            PH_ABIT_LOW, PH_DBIT_LOW:
            begin
                result.scl_low = 1'b1;
                result.sda_low = !shift_reg[7];
            end
            PH_ABIT_HIGH, PH_DBIT_HIGH:
            begin
                result.sda_low = !shift_reg[7];
            end
            PH_AACK_LOW, PH_DACK_LOW, PH_RBIT_LOW:
            begin
                result.scl_low = 1'b1;
            end
            PH_AACK_HIGH, PH_DACK_HIGH:
            begin
                result.tx_taken = ack_ok && (bytes_left_reg != 8'd0)
                                  && !(phase_reg == PH_AACK_HIGH && is_read_reg);
            end
            PH_RBIT_HIGH:
            begin
                if (bit_inc >= BITS_PER_BYTE)
                begin
                    result.rx_valid = 1'b1;
                    result.rx_byte  = rx_shift;
                end
            end
            PH_MACK_LOW:
            begin
                result.scl_low = 1'b1;
                result.sda_low = (bytes_left_reg != 8'd0);
            end
            PH_MACK_HIGH:
            begin
                result.sda_low = (bytes_left_reg != 8'd0);
            end
            PH_STOP2:
            begin
                result.sda_low = 1'b1;
            end
            PH_STOP3:
            begin
                result.done_res = 1'b1;
                result.status   = error_code_reg;
            end
            default:
            begin
                result.scl_low = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            is_read_reg    <= 1'b0;
            shift_reg      <= 8'd0;
            bit_index_reg  <= 4'd0;
            bytes_left_reg <= 8'd0;
            try_count_reg  <= 4'd0;
            error_code_reg <= 2'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            shift_reg      <= shift_next;
            bit_index_reg  <= bit_index_next;
            bytes_left_reg <= bytes_left_next;
            try_count_reg  <= try_count_next;
            error_code_reg <= error_code_next;
        end
    end

endmodule

// File: src/i2cm_out_stage.sv
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    input  i2cm_pkg::i2cm_out_t load_data,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cm_pkg::i2cm_out_t out_data
);
    import i2cm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    i2cm_out_t data_reg;

    // A new result may enter whenever the held one is gone or leaving now.
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/bitbang_i2c_master.sv
// ----------------------------------------------------------------------------
// Bit-banged I2C master
// Seven-bit address I2C master that advances one half-bit phase per word.
// ----------------------------------------------------------------------------
// Each input word is one half-bit tick: it carries the sampled SDA level and
// may request a write or read transaction. Every accepted word yields exactly
// one result word with the SCL/SDA drive levels for that tick, write-byte
// consumption, received bytes and the completion status.
// A word passes an input register and then the phase logic into a result
// register, where its result is offered to the receiver. One word is
// accepted per cycle while the result side keeps up; throughput is set by
// the single phase register, which moves once per word.
// When the receiver stalls, the result register holds its word and the input
// register holds one more; in_ready drops only once both are full.
// Reset returns the sequencer to idle, empties both registers and loads the
// acknowledge retry limits with 10 (write) and 4 (read). The limits are
// written through the cfg channel, which is always ready; the user must
// write them only while idle, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bitbang_i2c_master (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  i2cm_pkg::i2cm_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output i2cm_pkg::i2cm_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import i2cm_pkg::*;

    logic      advance;
    logic      item_valid;
    i2cm_in_t  item;
    i2cm_out_t result;
    logic      step;

    logic [3:0] write_ack_tries_reg, write_ack_tries_next;
    logic [3:0] read_ack_tries_reg,  read_ack_tries_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        write_ack_tries_next = write_ack_tries_reg;
        read_ack_tries_next  = read_ack_tries_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WRITE_ACK_TRIES: write_ack_tries_next = cfg_data;
                CFG_READ_ACK_TRIES:  read_ack_tries_next  = cfg_data;
                default:             write_ack_tries_next = write_ack_tries_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ack_tries_reg <= WRITE_ACK_TRIES_RESET;
            read_ack_tries_reg  <= READ_ACK_TRIES_RESET;
        end
        else
        begin
            write_ack_tries_reg <= write_ack_tries_next;
            read_ack_tries_reg  <= read_ack_tries_next;
        end
    end

    assign step = item_valid && advance;

    i2cm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cm_fsm u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .item            (item),
        .write_ack_tries (write_ack_tries_reg),
        .read_ack_tries  (read_ack_tries_reg),
        .result          (result)
    );

    i2cm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_data  (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// File: tb/sv/bitbang_i2c_master_tb.sv
// ----------------------------------------------------------------------------
// Bit-banged I2C master testbench
// Drives half-bit tick words into the master and checks every result word
// against a cycle-free model of the phase sequencer. Transactions are built
// around the predicted phase, so acknowledge ticks carry chosen SDA levels;
// read-bit ticks carry random ones. Both handshake sides idle at random.
// The retry limits are changed between phases while the bus is quiet.
// ----------------------------------------------------------------------------
module bitbang_i2c_master_tb;
    import i2cm_pkg::*;

    typedef enum int {
        VERDICT_RETRY,
        VERDICT_ACKED,
        VERDICT_GIVE_UP
    } ack_verdict_t;

    typedef enum int {
        SDA_ACK,
        SDA_MIXED,
        SDA_NAK,
        SDA_DATA_NAK
    } sda_mode_t;

    // Model of the sequencer plus the queue of result words it has predicted.
    class tick_scoreboard;
        logic [3:0] wr_limit;
        logic [3:0] rd_limit;
        phase_t     ph;
        logic       rd_xfer;
        logic [7:0] shifter;
        logic [3:0] bit_cnt;
        logic [7:0] left;
        logic [3:0] attempts;
        logic [1:0] err;
        i2cm_out_t  expected_words[$];
        int         error_count;

        function new();
            wr_limit    = WRITE_ACK_TRIES_RESET;
            rd_limit    = READ_ACK_TRIES_RESET;
            ph          = PH_IDLE;
            rd_xfer     = 1'b0;
            shifter     = '0;
            bit_cnt     = '0;
            left        = '0;
            attempts    = '0;
            err         = STATUS_OK;
            error_count = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [3:0] value);
            if (idx == CFG_WRITE_ACK_TRIES)
                wr_limit = value;
            else if (idx == CFG_READ_ACK_TRIES)
                rd_limit = value;
        endfunction

        // The attempt that reaches the limit fails even if SDA was low.
        function ack_verdict_t ack_attempt(logic [3:0] limit, logic sda);
            attempts = attempts + 4'd1;
            if (attempts == limit)
                return VERDICT_GIVE_UP;
            if (!sda)
                return VERDICT_ACKED;
            return VERDICT_RETRY;
        endfunction

        function logic load_next_byte(logic [7:0] tx);
            if (left == 8'd0) begin
                ph = PH_STOP1;
                return 1'b0;
            end
            shifter = tx;
            left    = left - 8'd1;
            bit_cnt = '0;
            ph      = PH_DBIT_LOW;
            return 1'b1;
        endfunction

        function i2cm_out_t bus_tick(i2cm_in_t w);
            i2cm_out_t    o;
            ack_verdict_t v;
            o = '0;
            case (ph)
                PH_IDLE:
                begin
                    if (w.action == ACT_START_WR || w.action == ACT_START_RD)
                    begin
                        rd_xfer  = (w.action == ACT_START_RD);
                        shifter  = {w.dev_address, rd_xfer};
                        left     = w.byte_count;
                        bit_cnt  = '0;
                        attempts = '0;
                        err      = STATUS_OK;
                        ph       = PH_START1;
                    end
                end
                PH_START1:
                begin
                    o.sda_low = 1'b1;
                    ph        = PH_START2;
                end
                PH_START2:
                begin
                    o.scl_low = 1'b1;
                    o.sda_low = 1'b1;
                    ph        = PH_ABIT_LOW;
                end
                PH_ABIT_LOW, PH_DBIT_LOW:
                begin
                    o.scl_low = 1'b1;
                    o.sda_low = ~shifter[7];
                    ph        = phase_t'(ph + 5'd1);
                end
                PH_ABIT_HIGH, PH_DBIT_HIGH:
                begin
                    o.sda_low = ~shifter[7];
                    shifter   = {shifter[6:0], 1'b0};
                    bit_cnt   = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        attempts = '0;
                        ph       = phase_t'(ph + 5'd1);
                    end
                    else
                        ph = phase_t'(ph - 5'd1);
                end
                PH_AACK_LOW, PH_DACK_LOW, PH_RBIT_LOW:
                begin
                    o.scl_low = 1'b1;
                    ph        = phase_t'(ph + 5'd1);
                end
                PH_AACK_HIGH:
                begin
                    v = ack_attempt(rd_xfer ? rd_limit : wr_limit, w.sda_in);
                    if (v == VERDICT_GIVE_UP)
                    begin
                        err = STATUS_ADDR_NAK;
                        ph  = PH_STOP1;
                    end
                    else if (v == VERDICT_RETRY)
                        ph = PH_AACK_LOW;
                    else if (rd_xfer)
                    begin
                        if (left == 8'd0)
                            ph = PH_STOP1;
                        else
                        begin
                            bit_cnt = '0;
                            shifter = '0;
                            ph      = PH_RBIT_LOW;
                        end
                    end
                    else
                        o.tx_taken = load_next_byte(w.tx_byte);
                end
                PH_DACK_HIGH:
                begin
                    v = ack_attempt(wr_limit, w.sda_in);
                    if (v == VERDICT_GIVE_UP)
                    begin
                        err = STATUS_DATA_NAK;
                        ph  = PH_STOP1;
                    end
                    else if (v == VERDICT_RETRY)
                        ph = PH_DACK_LOW;
                    else
                        o.tx_taken = load_next_byte(w.tx_byte);
                end
                PH_RBIT_HIGH:
                begin
                    shifter = {shifter[6:0], w.sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        o.rx_valid = 1'b1;
                        o.rx_byte  = shifter;
                        left       = left - 8'd1;
                        ph         = PH_MACK_LOW;
                    end
                    else
                        ph = PH_RBIT_LOW;
                end
                PH_MACK_LOW:
                begin
                    // The last byte gets a released SDA (a NACK), the others an ACK.
                    o.scl_low = 1'b1;
                    o.sda_low = (left != 8'd0);
                    ph        = PH_MACK_HIGH;
                end
                PH_MACK_HIGH:
                begin
                    o.sda_low = (left != 8'd0);
                    if (left == 8'd0)
                        ph = PH_STOP1;
                    else
                    begin
                        bit_cnt = '0;
                        shifter = '0;
                        ph      = PH_RBIT_LOW;
                    end
                end
                PH_STOP1:
                begin
                    o.scl_low = 1'b1;
                    o.sda_low = 1'b1;
                    ph        = PH_STOP2;
                end
                PH_STOP2:
                begin
                    o.sda_low = 1'b1;
                    ph        = PH_STOP3;
                end
                PH_STOP3:
                begin
                    o.done_res = 1'b1;
                    o.status   = err;
                    ph         = PH_IDLE;
                end
                default:
                    ph = PH_IDLE;
            endcase
            o.busy_res = (ph != PH_IDLE);
            return o;
        endfunction

        function void note_input(i2cm_in_t w);
            expected_words.push_back(bus_tick(w));
        endfunction

        task report(string what, int got_v, int want_v);
            error_count++;
            $display("ERROR: result %s got 0x%0h, expected 0x%0h", what, got_v, want_v);
        endtask

        task check_result(i2cm_out_t got);
            i2cm_out_t want;
            if (expected_words.size() == 0)
            begin
                report("word with nothing outstanding", int'(got), 0);
                return;
            end
            want = expected_words.pop_front();
            if (got.scl_low !== want.scl_low)
                report("scl_low", got.scl_low, want.scl_low);
            if (got.sda_low !== want.sda_low)
                report("sda_low", got.sda_low, want.sda_low);
            if (got.tx_taken !== want.tx_taken)
                report("tx_taken", got.tx_taken, want.tx_taken);
            if (got.rx_valid !== want.rx_valid)
                report("rx_valid", got.rx_valid, want.rx_valid);
            if (got.rx_byte !== want.rx_byte)
                report("rx_byte", got.rx_byte, want.rx_byte);
            if (got.done_res !== want.done_res)
                report("done_res", got.done_res, want.done_res);
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.busy_res !== want.busy_res)
                report("busy_res", got.busy_res, want.busy_res);
        endtask

        function bit bus_busy();
            return ph != PH_IDLE;
        endfunction

        function phase_t current_phase();
            return ph;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    i2cm_in_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    i2cm_out_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tick_scoreboard sb;
    int             words_sent = 0;
    int             in_left = 0;
    int             out_left = 0;
    bit             in_calm = 1'b0;
    bit             out_calm = 1'b0;

    bitbang_i2c_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gaps come in stretches; some stretches have no idling at all.
    function automatic int draw_gap(inout int left, inout bit calm);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(10, 60);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_word(i2cm_in_t w);
        int gap;
        gap = draw_gap(in_left, in_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    // SDA is chosen from the phase the word will meet, so acknowledges land.
    function automatic logic pick_sda(sda_mode_t mode);
        phase_t p;
        p = sb.current_phase();
        if (p == PH_AACK_HIGH || p == PH_DACK_HIGH)
        begin
            case (mode)
                SDA_ACK:      return 1'b0;
                SDA_MIXED:    return ($urandom_range(0, 4) >= 3);
                SDA_NAK:      return 1'b1;
                SDA_DATA_NAK: return (p == PH_DACK_HIGH);
                default:      return 1'b0;
            endcase
        end
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic run_transaction(action_t act, logic [6:0] addr, logic [7:0] count,
                                   sda_mode_t mode);
        i2cm_in_t w;
        w.action      = act;
        w.dev_address = addr;
        w.byte_count  = count;
        w.tx_byte     = 8'($urandom_range(0, 255));
        w.sda_in      = 1'($urandom_range(0, 1));
        send_word(w);
        while (sb.bus_busy())
        begin
            // Now and then a request arrives mid-transaction and must be ignored.
            if ($urandom_range(0, 15) == 0)
                w.action = 2'($urandom_range(1, 3));
            else
                w.action = ACT_TICK;
            w.dev_address = 7'($urandom_range(0, 127));
            w.byte_count  = 8'($urandom_range(0, 255));
            w.tx_byte     = 8'($urandom_range(0, 255));
            w.sda_in      = pick_sda(sda_mode_t'(mode));
            send_word(w);
        end
    endtask

    task automatic idle_noise(int n);
        i2cm_in_t w;
        repeat (n)
        begin
            w.action      = $urandom_range(0, 1) ? ACT_RESERVED : ACT_TICK;
            w.dev_address = 7'($urandom_range(0, 127));
            w.byte_count  = 8'($urandom_range(0, 255));
            w.tx_byte     = 8'($urandom_range(0, 255));
            w.sda_in      = 1'($urandom_range(0, 1));
            send_word(w);
        end
    endtask

    task automatic random_transactions(int target);
        int        stop_at;
        int        pick;
        logic [7:0] count;
        sda_mode_t mode;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
                idle_noise($urandom_range(1, 4));
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    count = 8'($urandom_range(0, 3));
                else if (pick < 18)
                    count = 8'($urandom_range(4, 12));
                else
                    count = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    mode = SDA_ACK;
                else if (pick < 8)
                    mode = SDA_MIXED;
                else if (pick < 9)
                    mode = SDA_NAK;
                else
                    mode = SDA_DATA_NAK;
                // Long byte counts are cut short at the address acknowledge.
                if (count > 8'd12)
                    mode = SDA_NAK;
                run_transaction($urandom_range(0, 1) ? ACT_START_RD : ACT_START_WR,
                                7'($urandom_range(0, 127)), count, mode);
            end
        end
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_limits(logic [3:0] wr, logic [3:0] rd);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WRITE_ACK_TRIES;
        cfg_data  <= wr;
        do @(posedge clk); while (!cfg_ready);
        sb.set_limit(CFG_WRITE_ACK_TRIES, wr);
        cfg_index <= CFG_READ_ACK_TRIES;
        cfg_data  <= rd;
        do @(posedge clk); while (!cfg_ready);
        sb.set_limit(CFG_READ_ACK_TRIES, rd);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    initial
    begin : result_sink
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(out_left, out_calm);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin : stimulus
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: plain transfers, empty transfers and both failures.
        idle_noise(3);
        run_transaction(ACT_START_WR, 7'h00, 8'd1, SDA_ACK);
        run_transaction(ACT_START_RD, 7'h7F, 8'd2, SDA_ACK);
        run_transaction(ACT_START_WR, 7'h3C, 8'd0, SDA_ACK);
        run_transaction(ACT_START_RD, 7'h43, 8'd0, SDA_ACK);
        run_transaction(ACT_START_WR, 7'h55, 8'd255, SDA_NAK);
        run_transaction(ACT_START_WR, 7'h2A, 8'd2, SDA_DATA_NAK);
        run_transaction(ACT_START_RD, 7'h19, 8'd1, SDA_NAK);
        finish_phase();

        // A limit of one gives up on the first attempt even when acknowledged.
        set_limits(4'd1, 4'd1);
        run_transaction(ACT_START_WR, 7'h12, 8'd1, SDA_ACK);
        run_transaction(ACT_START_RD, 7'h6D, 8'd1, SDA_ACK);
        random_transactions(150);
        finish_phase();

        set_limits(4'd15, 4'd15);
        run_transaction(ACT_START_WR, 7'h01, 8'd3, SDA_MIXED);
        run_transaction(ACT_START_RD, 7'h7E, 8'd3, SDA_MIXED);
        random_transactions(150);
        finish_phase();

        set_limits(4'd1, 4'd15);
        random_transactions(150);
        finish_phase();

        set_limits(4'd15, 4'd1);
        random_transactions(150);
        finish_phase();

        repeat (3)
        begin
            set_limits(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
            random_transactions(180);
            finish_phase();
        end

        repeat (10) @(posedge clk);
        if (sb.error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
src/i2cm_pkg.sv
src/i2cm_in_stage.sv
src/i2cm_fsm.sv
src/i2cm_out_stage.sv
src/bitbang_i2c_master.sv
tb/sv/bitbang_i2c_master_tb.sv
